// ===== src/external_index_renumbering_assert.svh =====
// ---------------------------------------------------------------------------
// External index renumbering assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ---------------------------------------------------------------------------
`ifndef EXTERNAL_INDEX_RENUMBERING_ASSERT_SVH
`define EXTERNAL_INDEX_RENUMBERING_ASSERT_SVH
`ifndef SYNTHESIS
`define EIR_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define EIR_ASSERT_IMP(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define EIR_ASSERT(name, clk, rstn, prop)
`define EIR_ASSERT_IMP(name, clk, rstn, pre, post)
`endif
`endif

// ===== src/eir_pkg.sv =====
// ---------------------------------------------------------------------------
// External index renumbering package
// Payload types, status codes and controller interface structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package eir_pkg;
  localparam int unsigned ExtDepthDefault  = 1024;
  localparam int unsigned IndexBitsDefault = 31;
  localparam int unsigned GidxW = 31;
  localparam int unsigned LidxW = 32;
  localparam int unsigned CntW  = 11;
  localparam int unsigned CfgW  = 31;

  localparam logic [2:0] StInternal  = 3'd0;
  localparam logic [2:0] StNew       = 3'd1;
  localparam logic [2:0] StDuplicate = 3'd2;
  localparam logic [2:0] StFull      = 3'd3;
  localparam logic [2:0] StNotFound  = 3'd4;

  localparam logic ReqAdd       = 1'b0;
  localparam logic ReqTranslate = 1'b1;

  localparam logic CfgFirstRow  = 1'b0;
  localparam logic CfgLocalRows = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [GidxW-1:0] global_index;
  } in_t;

  typedef struct packed {
    logic [LidxW-1:0] local_index;
    logic [2:0]       status;
    logic [CntW-1:0]  ext_total;
    logic [CntW-1:0]  ext_below;
    logic [CntW-1:0]  ext_above;
  } out_t;

  typedef struct packed {
    logic load;
    logic rd_mid;
    logic cmp;
    logic sh_rd;
    logic sh_wr;
    logic ins;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic internal;
    logic srch_done;
    logic need_ins;
    logic shift_done;
  } stat_t;
endpackage

// ===== src/eir_ctrl.sv =====
// ---------------------------------------------------------------------------
// External index renumbering controller
// Sequences search, shift, insert and result transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module eir_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  eir_pkg::stat_t stat_i,
  output eir_pkg::cmd_t  cmd_o
);
  import eir_pkg::*;

  typedef enum logic [2:0] {
    SIdle, SSearch, SCmp, SShRd, SShWr, SIns, SFin
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   emit;

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign emit = (state_q == SFin) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == SIdle) && in_valid_i;
    cmd_o.rd_mid = (state_q == SSearch) && !stat_i.internal && !stat_i.srch_done;
    cmd_o.cmp    = (state_q == SCmp);
    cmd_o.sh_rd  = (state_q == SShRd) && !stat_i.shift_done;
    cmd_o.sh_wr  = (state_q == SShWr);
    cmd_o.ins    = (state_q == SIns);
    cmd_o.emit   = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_valid_i) state_q <= SSearch;
        end
        SSearch: begin
          if (stat_i.internal) state_q <= SFin;
          else if (!stat_i.srch_done) state_q <= SCmp;
          else if (stat_i.need_ins) state_q <= SShRd;
          else state_q <= SFin;
        end
        SCmp: state_q <= SSearch;
        SShRd: begin
          if (stat_i.shift_done) state_q <= SIns;
          else state_q <= SShWr;
        end
        SShWr: state_q <= SShRd;
        SIns: state_q <= SFin;
        SFin: begin
          if (emit) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== src/eir_datapath.sv =====
// ---------------------------------------------------------------------------
// External index renumbering datapath
// Sorted index store, binary search, shift-insert and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module eir_datapath #(
  parameter int unsigned EXT_DEPTH  = eir_pkg::ExtDepthDefault,
  parameter int unsigned INDEX_BITS = eir_pkg::IndexBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  eir_pkg::in_t           in_data_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [eir_pkg::CfgW-1:0] cfg_data_i,
  input  eir_pkg::cmd_t          cmd_i,
  output eir_pkg::stat_t         stat_o,
  output eir_pkg::out_t          out_data_o
);
  import eir_pkg::*;

  localparam int unsigned AW = $clog2(EXT_DEPTH);
  localparam int unsigned CW = $clog2(EXT_DEPTH + 1);

  logic [INDEX_BITS-1:0] mem [EXT_DEPTH];
  logic [INDEX_BITS-1:0] rdata_q;
  logic [INDEX_BITS-1:0] first_q, rows_q, g_q, g_in;
  logic                  req_q, internal_q, full_q, found_q;
  logic [CW-1:0]         lo_q, hi_q, mid_q, j_q, mid;
  logic [CW-1:0]         cnt_q, below_q, above_q;
  logic [INDEX_BITS:0]   last;
  logic                  internal_d;
  out_t                  out_q, res;

  assign g_in       = INDEX_BITS'(in_data_i.global_index);
  assign last       = {1'b0, first_q} + {1'b0, rows_q};
  assign internal_d = (g_in >= first_q) && ({1'b0, g_in} < last);
  assign mid        = lo_q + ((hi_q - lo_q) >> 1);

  assign stat_o.internal   = internal_q;
  assign stat_o.srch_done  = (lo_q >= hi_q);
  assign stat_o.need_ins   = (req_q == ReqAdd) && !found_q && !full_q;
  assign stat_o.shift_done = (j_q == lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      rows_q  <= '0;
      cnt_q   <= '0;
      below_q <= '0;
      above_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgFirstRow) first_q <= INDEX_BITS'(cfg_data_i);
        else rows_q <= INDEX_BITS'(cfg_data_i);
      end
      if (cmd_i.ins) begin
        cnt_q <= cnt_q + CW'(1);
        if (g_q < first_q) below_q <= below_q + CW'(1);
        else above_q <= above_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      g_q        <= g_in;
      req_q      <= in_data_i.req_type;
      internal_q <= internal_d;
      full_q     <= (cnt_q >= CW'(EXT_DEPTH));
      found_q    <= 1'b0;
      lo_q       <= '0;
      hi_q       <= cnt_q;
      j_q        <= cnt_q;
    end
    if (cmd_i.rd_mid) begin
      mid_q   <= mid;
      rdata_q <= mem[mid[AW-1:0]];
    end
    if (cmd_i.cmp) begin
      if (rdata_q < g_q) lo_q <= mid_q + CW'(1);
      else hi_q <= mid_q;
      if (rdata_q == g_q) found_q <= 1'b1;
    end
    if (cmd_i.sh_rd) rdata_q <= mem[AW'(j_q - CW'(1))];
    if (cmd_i.sh_wr) begin
      mem[j_q[AW-1:0]] <= rdata_q;
      j_q <= j_q - CW'(1);
    end
    if (cmd_i.ins) mem[lo_q[AW-1:0]] <= g_q;
    if (cmd_i.emit) out_q <= res;
  end

  always_comb begin
    res             = '0;
    res.ext_total   = CntW'(cnt_q);
    res.ext_below   = CntW'(below_q);
    res.ext_above   = CntW'(above_q);
    if (internal_q) begin
      res.status = StInternal;
      if (req_q == ReqTranslate) res.local_index = LidxW'(g_q - first_q);
    end else if (req_q == ReqAdd) begin
      if (found_q) res.status = StDuplicate;
      else if (full_q) res.status = StFull;
      else res.status = StNew;
    end else if (found_q) begin
      res.status      = StDuplicate;
      res.local_index = LidxW'(rows_q) + LidxW'(lo_q);
    end else begin
      res.status = StNotFound;
    end
  end

  assign out_data_o = out_q;
endmodule

// ===== src/external_index_renumbering.sv =====
// ---------------------------------------------------------------------------
// External index renumbering
// Global-to-local column index map for one block of owned rows.
// ---------------------------------------------------------------------------
// An internal item goes from the search state straight to the result. An
// external item runs binary search steps, each a read of the middle entry
// and a compare; a new external add then moves each stored entry above the
// insert point up by one, a read and a write per entry, and inserts. One
// item is in work at a time; a finished result waits in the output register.
`timescale 1ns / 1ps
`include "external_index_renumbering_assert.svh"
module external_index_renumbering #(
  parameter int unsigned EXT_DEPTH  = eir_pkg::ExtDepthDefault,
  parameter int unsigned INDEX_BITS = eir_pkg::IndexBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  eir_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output eir_pkg::out_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [eir_pkg::CfgW-1:0] cfg_data_i
);
  import eir_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  eir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  eir_datapath #(
    .EXT_DEPTH  (EXT_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  `EIR_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o, out_data_o.status <= StNotFound)
  `EIR_ASSERT_IMP(a_count_sum, clk_i, rst_ni, out_valid_o, out_data_o.ext_total == CntW'(out_data_o.ext_below + out_data_o.ext_above))
  `EIR_ASSERT(a_busy_no_take, clk_i, rst_ni, !(cmd.load && cmd.emit))
endmodule
